// ===== src/art_pkg.sv =====
package art_pkg;

	localparam int MAX_WINDOWS = 16;
	localparam int ADDR_BITS   = 48;
	localparam int FIELD_W     = 48;
	localparam int TAG_W       = 8;
	localparam int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
	localparam int END_W       = ADDR_BITS + 1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_ZERO     = 3'd2,
		ST_OVERLAP  = 3'd3,
		ST_NOMATCH  = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef enum logic {
		REQ_REGISTER = 1'b0,
		REQ_LOOKUP   = 1'b1
	} req_t;

	// Data handed from one cell to the next during the resolve cycle.
	typedef struct packed {
		logic                 taken;
		logic                 ovl;
		logic [IDX_W-1:0]     idx;
		logic [ADDR_BITS-1:0] offset;
		logic [TAG_W-1:0]     tag;
	} art_link_t;

	// Write port shared by all cells; each cell has its own enable.
	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [END_W-1:0]     win_end;
		logic [TAG_W-1:0]     tag;
	} art_wr_t;

endpackage

// ===== src/art_cell.sv =====
module art_cell
	import art_pkg::*;
(
	input  logic                 clk,
	input  logic                 capture,
	input  logic                 active,
	input  logic [ADDR_BITS-1:0] cmp_addr,
	input  logic [END_W-1:0]     cmp_end,
	input  logic                 wr_en,
	input  art_wr_t              wr,
	input  logic [IDX_W-1:0]     cell_idx,
	input  art_link_t            link_in,
	output art_link_t            link_out
);

	logic [ADDR_BITS-1:0] base_q;
	logic [END_W-1:0]     end_q;
	logic [TAG_W-1:0]     tag_q;

	logic                 hit_s1;
	logic                 ovl_s1;
	logic [ADDR_BITS-1:0] off_s1;

	logic [END_W-1:0] addr_ext;
	logic [END_W-1:0] base_ext;
	logic             hit_d;
	logic             ovl_d;
	logic             grant;

	assign addr_ext = {1'b0, cmp_addr};
	assign base_ext = {1'b0, base_q};
	assign hit_d    = active && (cmp_addr >= base_q) && (addr_ext < end_q);
	assign ovl_d    = active && !((addr_ext >= end_q) || (cmp_end <= base_ext));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_q <= wr.base;
			end_q  <= wr.win_end;
			tag_q  <= wr.tag;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			hit_s1 <= hit_d;
			ovl_s1 <= ovl_d;
			off_s1 <= cmp_addr - base_q;
		end
	end

	// Only the first hit along the chain claims the result.
	assign grant = hit_s1 && !link_in.taken;

	always_comb begin
		link_out       = link_in;
		link_out.taken = link_in.taken | hit_s1;
		link_out.ovl   = link_in.ovl | ovl_s1;
		if (grant) begin
			link_out.idx    = cell_idx;
			link_out.offset = off_s1;
			link_out.tag    = tag_q;
		end
	end

endmodule

// ===== src/address_region_table_unit.sv =====
// Table of up to 16 half-open address windows, one per cell in a chain.
// A request with req_type 0 registers the window [address, address +
// region_size) with its handler tag, unless the table is full, the size is
// zero, the end passes the top of the address space, or it overlaps a stored
// window. A request with req_type 1 returns the first window, in slot order,
// that holds the address. On the accept edge every cell compares the request
// against its window and registers the result; then, once the output
// register is empty or out_stall is low, the chain picks the first hit,
// writes the new window and loads the output register. A new request is
// taken once that result has been loaded, so requests never overlap.
module address_region_table_unit
	import art_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [FIELD_W-1:0] address,
	input  logic [FIELD_W-1:0] region_size,
	input  logic [TAG_W-1:0]   handler_tag,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [3:0]         entry_index,
	output logic [FIELD_W-1:0] offset,
	output logic [TAG_W-1:0]   tag_out
);

	logic                   busy_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	status_t                status_q;
	logic [3:0]             index_q;
	logic [FIELD_W-1:0]     offset_q;
	logic [TAG_W-1:0]       tag_q;

	req_t                   type_s1;
	logic                   full_s1;
	logic                   zero_s1;
	logic                   ovf_s1;
	art_wr_t                wr_s1;

	logic                   accept;
	logic                   out_free;
	logic                   resolve;
	logic [ADDR_BITS-1:0]   addr_m;
	logic [ADDR_BITS-1:0]   size_m;
	logic [END_W-1:0]       end_d;
	logic [MAX_WINDOWS-1:0] active;
	logic [MAX_WINDOWS-1:0] wr_en;
	art_link_t              link [MAX_WINDOWS+1];

	status_t                status_d;
	logic [3:0]             index_d;
	logic [FIELD_W-1:0]     offset_d;
	logic [TAG_W-1:0]       tag_d;
	logic                   commit;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign out_free = !out_valid_q || !out_stall;
	assign resolve  = busy_q && out_free;

	assign addr_m = address[ADDR_BITS-1:0];
	assign size_m = region_size[ADDR_BITS-1:0];
	assign end_d  = {1'b0, addr_m} + {1'b0, size_m};

	assign link[0] = '0;

	for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
		assign active[i] = CNT_W'(i) < count_q;
		assign wr_en[i]  = commit && (count_q == CNT_W'(i));

		art_cell u_cell (
			.clk      (clk),
			.capture  (accept),
			.active   (active[i]),
			.cmp_addr (addr_m),
			.cmp_end  (end_d),
			.wr_en    (wr_en[i]),
			.wr       (wr_s1),
			.cell_idx (IDX_W'(i)),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1         <= req_t'(req_type);
			full_s1         <= count_q >= CNT_W'(MAX_WINDOWS);
			zero_s1         <= size_m == '0;
			ovf_s1          <= end_d[ADDR_BITS] && (end_d[ADDR_BITS-1:0] != '0);
			wr_s1.base      <= addr_m;
			wr_s1.win_end   <= end_d;
			wr_s1.tag       <= handler_tag;
		end
	end

	always_comb begin
		status_d = ST_OK;
		index_d  = '0;
		offset_d = '0;
		tag_d    = '0;
		commit   = 1'b0;
		if (type_s1 == REQ_LOOKUP) begin
			if (link[MAX_WINDOWS].taken) begin
				index_d  = 4'(link[MAX_WINDOWS].idx);
				offset_d = FIELD_W'(link[MAX_WINDOWS].offset);
				tag_d    = link[MAX_WINDOWS].tag;
			end else begin
				status_d = ST_NOMATCH;
			end
		end else if (full_s1) begin
			status_d = ST_FULL;
		end else if (zero_s1) begin
			status_d = ST_ZERO;
		end else if (ovf_s1) begin
			status_d = ST_OVERFLOW;
		end else if (link[MAX_WINDOWS].ovl) begin
			status_d = ST_OVERLAP;
		end else begin
			index_d = 4'(count_q);
			commit  = resolve;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (resolve) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (resolve) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (resolve) begin
			status_q <= status_d;
			index_q  <= index_d;
			offset_q <= offset_d;
			tag_q    <= tag_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = index_q;
	assign offset      = offset_q;
	assign tag_out     = tag_q;

endmodule
